// ===== hw/rtl/spfe_pkg.sv =====
// package: widths, constants, codes and control store of the power feature expander
`timescale 1ns / 1ps
package spfe_pkg;

	localparam int MAX_POWER   = 8;
	localparam int MAX_COLUMNS = 256;
	localparam int COL_W       = $clog2(MAX_COLUMNS);
	localparam int POW_W       = $clog2(MAX_POWER + 1);
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;

	localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
	localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAX_POWER   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS_ENABLE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEVEL  = 2'd2;

	// divider: one quotient bit per cycle for the 33-bit quotient of 2^32
	localparam int DIV_STEPS = 33;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

	localparam int STEP_W = 3;
	localparam int OP_W   = 3;
	localparam int COND_W = 2;

	localparam logic [OP_W-1:0] OP_NOP   = 3'd0;
	localparam logic [OP_W-1:0] OP_LOAD  = 3'd1;
	localparam logic [OP_W-1:0] OP_EMIT  = 3'd2;
	localparam logic [OP_W-1:0] OP_RND   = 3'd3;
	localparam logic [OP_W-1:0] OP_RECIP = 3'd4;
	localparam logic [OP_W-1:0] OP_BIAS  = 3'd5;

	localparam logic [COND_W-1:0] C_NEXT   = 2'd0;
	localparam logic [COND_W-1:0] C_ALWAYS = 2'd1;
	localparam logic [COND_W-1:0] C_DLAST  = 2'd2;
	localparam logic [COND_W-1:0] C_NEG    = 2'd3;

	localparam logic [STEP_W-1:0] S_LOAD   = 3'd0;
	localparam logic [STEP_W-1:0] S_EMIT   = 3'd1;
	localparam logic [STEP_W-1:0] S_RND    = 3'd2;
	localparam logic [STEP_W-1:0] S_BRANCH = 3'd3;
	localparam logic [STEP_W-1:0] S_RECIP  = 3'd4;
	localparam logic [STEP_W-1:0] S_BIAS   = 3'd5;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [COND_W-1:0] cond;
		logic [STEP_W-1:0] target;
	} ctrl_t;

	function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
		ctrl_t w;
		unique case (step)
			S_LOAD:   w = '{op: OP_LOAD,  cond: C_NEXT,   target: S_LOAD};
			S_EMIT:   w = '{op: OP_EMIT,  cond: C_DLAST,  target: S_BRANCH};
			S_RND:    w = '{op: OP_RND,   cond: C_ALWAYS, target: S_EMIT};
			S_BRANCH: w = '{op: OP_NOP,   cond: C_NEG,    target: S_BIAS};
			S_RECIP:  w = '{op: OP_RECIP, cond: C_ALWAYS, target: S_EMIT};
			S_BIAS:   w = '{op: OP_BIAS,  cond: C_ALWAYS, target: S_LOAD};
			default:  w = '{op: OP_NOP,   cond: C_ALWAYS, target: S_LOAD};
		endcase
		return w;
	endfunction

endpackage

// ===== hw/rtl/spfe_if.sv =====
// interfaces: sample channel, feature channel and register write channel
`timescale 1ns / 1ps
interface spfe_in_if import spfe_pkg::*; ();
	logic               valid;
	logic               ready;
	logic signed [31:0] sample;
	logic               row_end;

	modport source (output valid, sample, row_end, input ready);
	modport sink (input valid, sample, row_end, output ready);
endinterface

interface spfe_out_if import spfe_pkg::*; ();
	logic               valid;
	logic               ready;
	logic signed [31:0] value;
	logic signed [4:0]  exponent;
	logic [COL_W-1:0]   base_column;
	logic               saturated;
	logic               last;

	modport source (output valid, value, exponent, base_column, saturated, last, input ready);
	modport sink (input valid, value, exponent, base_column, saturated, last, output ready);
endinterface

interface spfe_cfg_if import spfe_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/signed_power_feature_expander.sv =====
// top level: microcoded power and reciprocal-power feature expander
`timescale 1ns / 1ps
// Each sample x yields x^1..x^D and then (1/c)^1..(1/c)^D, with D the clamped max_power,
// c the sample pushed out to +/-clip_level, and each power the rounded, saturated product
// of the previous one with its base; a row's last sample adds a 1.0 result when bias is on.
// The 33-step restoring divider for 2^32/c starts when the sample is taken and runs
// beside the positive powers, and each further power costs two steps of the sequencer
// (one multiply, one round and saturate). A new sample is taken only between sequences.
module signed_power_feature_expander import spfe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	spfe_in_if.sink    samples,
	spfe_out_if.source features,
	spfe_cfg_if.sink   cfg
);

	logic [3:0]        max_power_q;
	logic              bias_enable_q;
	logic [30:0]       clip_level_q;

	logic [STEP_W-1:0] step_q;
	ctrl_t             cw;
	logic              go;
	logic [STEP_W-1:0] step_nx;

	logic signed [31:0] acc_q;
	logic signed [31:0] base_q;
	logic signed [63:0] prod_q;
	logic               sticky_q;
	logic [POW_W-1:0]   d_q;
	logic               neg_q;
	logic               row_end_q;
	logic [COL_W-1:0]   col_q;
	logic [COL_W-1:0]   item_col_q;

	logic [31:0]          div_q;
	logic [31:0]          rem_q;
	logic [32:0]          quot_q;
	logic                 c_neg_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	logic               out_valid_q;
	logic signed [31:0] out_value_q;
	logic signed [4:0]  out_exp_q;
	logic [COL_W-1:0]   out_col_q;
	logic               out_sat_q;
	logic               out_last_q;

	logic [POW_W-1:0]   d_eff;
	logic [31:0]        clip_eff;
	logic               slot_free;
	logic               div_busy;
	logic               bias_now;
	logic               emit;
	logic               d_last;

	logic signed [63:0] prod_full;
	logic signed [63:0] rsum;
	logic               rnd_ovf;
	logic signed [31:0] rnd_val;
	logic [POW_W-1:0]   d_inc;
	logic signed [31:0] extreme;

	logic [31:0]        x_mag;
	logic [31:0]        c_mag;
	logic [32:0]        trial;
	logic               trial_ge;
	logic signed [31:0] recip_val;
	logic               recip_sat;
	logic [4:0]         d_ext;

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_power_q   <= 4'd2;
			bias_enable_q <= 1'b0;
			clip_level_q  <= 31'd66;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_MAX_POWER:   max_power_q   <= cfg.data[3:0];
				REG_BIAS_ENABLE: bias_enable_q <= cfg.data[0];
				REG_CLIP_LEVEL:  clip_level_q  <= cfg.data[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (max_power_q == 4'd0)
			d_eff = POW_W'(1);
		else if ({1'b0, max_power_q} > 5'(MAX_POWER))
			d_eff = POW_W'(MAX_POWER);
		else
			d_eff = POW_W'(max_power_q);
	end

	assign clip_eff = (clip_level_q == '0) ? 32'd1 : {1'b0, clip_level_q};

	// sequencer
	assign cw        = ucode(step_q);
	assign slot_free = !out_valid_q || features.ready;
	assign div_busy  = div_cnt_q != '0;
	assign bias_now  = row_end_q && bias_enable_q;
	assign d_last    = d_q == d_eff;

	always_comb begin
		unique case (cw.op)
			OP_LOAD:  go = samples.valid;
			OP_EMIT:  go = slot_free;
			OP_RECIP: go = !div_busy;
			OP_BIAS:  go = !bias_now || slot_free;
			default:  go = 1'b1;
		endcase
	end

	always_comb begin
		step_nx = step_q;
		if (go) begin
			unique case (cw.cond)
				C_ALWAYS: step_nx = cw.target;
				C_DLAST:  step_nx = d_last ? cw.target : step_q + STEP_W'(1);
				C_NEG:    step_nx = neg_q ? cw.target : step_q + STEP_W'(1);
				default:  step_nx = step_q + STEP_W'(1);
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			step_q <= S_LOAD;
		else
			step_q <= step_nx;
	end

	assign samples.ready = cw.op == OP_LOAD;

	// power datapath
	assign prod_full = acc_q * base_q;
	assign rsum      = prod_q + 64'sd32768;
	assign rnd_ovf   = !((&rsum[63:47]) || !(|rsum[63:47]));
	assign rnd_val   = rnd_ovf ? (rsum[63] ? Q_MIN : Q_MAX) : rsum[47:16];
	assign d_inc     = d_q + POW_W'(1);
	assign extreme   = (base_q[31] && d_inc[0]) ? Q_MIN : Q_MAX;

	// reciprocal of the clipped sample
	assign x_mag    = samples.sample[31] ? 32'(-samples.sample) : 32'(samples.sample);
	assign c_mag    = (x_mag < clip_eff) ? clip_eff : x_mag;
	assign trial    = {rem_q, div_cnt_q == DIV_CNT_W'(DIV_STEPS)};
	assign trial_ge = trial >= {1'b0, div_q};

	always_comb begin
		recip_sat = 1'b0;
		if (!c_neg_q) begin
			if (quot_q[32] || quot_q[31]) begin
				recip_val = Q_MAX;
				recip_sat = 1'b1;
			end else begin
				recip_val = quot_q[31:0];
			end
		end else if (quot_q[32] || (quot_q[31] && (|quot_q[30:0]))) begin
			recip_val = Q_MIN;
			recip_sat = 1'b1;
		end else begin
			recip_val = -quot_q[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
			col_q     <= '0;
		end else if (go && cw.op == OP_LOAD) begin
			div_cnt_q <= DIV_CNT_W'(DIV_STEPS);
			if (samples.row_end || col_q == COL_W'(MAX_COLUMNS - 1))
				col_q <= '0;
			else
				col_q <= col_q + COL_W'(1);
		end else if (div_busy) begin
			div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (go && cw.op == OP_LOAD) begin
			div_q   <= c_mag;
			rem_q   <= '0;
			c_neg_q <= samples.sample[31];
		end else if (div_busy) begin
			rem_q  <= trial_ge ? 32'(trial - {1'b0, div_q}) : trial[31:0];
			quot_q <= {quot_q[31:0], trial_ge};
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			case (cw.op)
				OP_LOAD: begin
					acc_q      <= samples.sample;
					base_q     <= samples.sample;
					sticky_q   <= 1'b0;
					d_q        <= POW_W'(1);
					neg_q      <= 1'b0;
					row_end_q  <= samples.row_end;
					item_col_q <= col_q;
				end
				OP_EMIT: prod_q <= prod_full;
				OP_RND: begin
					d_q <= d_inc;
					if (sticky_q) begin
						acc_q <= extreme;
					end else begin
						acc_q    <= rnd_val;
						sticky_q <= rnd_ovf;
					end
				end
				OP_RECIP: begin
					acc_q    <= recip_val;
					base_q   <= recip_val;
					sticky_q <= recip_sat;
					d_q      <= POW_W'(1);
					neg_q    <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// output register
	assign emit  = go && ((cw.op == OP_EMIT) || (cw.op == OP_BIAS && bias_now));
	assign d_ext = 5'(d_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit)
			out_valid_q <= 1'b1;
		else if (features.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (cw.op == OP_BIAS) begin
				out_value_q <= Q_ONE;
				out_exp_q   <= '0;
				out_col_q   <= '0;
				out_sat_q   <= 1'b0;
				out_last_q  <= 1'b1;
			end else begin
				out_value_q <= acc_q;
				out_exp_q   <= neg_q ? -d_ext : d_ext;
				out_col_q   <= item_col_q;
				out_sat_q   <= sticky_q;
				out_last_q  <= neg_q && d_last && !bias_now;
			end
		end
	end

	assign features.valid       = out_valid_q;
	assign features.value       = out_value_q;
	assign features.exponent    = out_exp_q;
	assign features.base_column = out_col_q;
	assign features.saturated   = out_sat_q;
	assign features.last        = out_last_q;

	// checks
	a_div_idle_on_request: assert property (@(posedge clk) disable iff (!arst_n)
		samples.valid && samples.ready |-> !div_busy)
		else $error("sample taken while divider still busy");

	a_sticky_holds: assert property (@(posedge clk) disable iff (!arst_n)
		sticky_q && go && cw.op == OP_RND |=> sticky_q)
		else $error("saturation flag dropped within a power sequence");

	a_power_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cw.op == OP_EMIT |-> d_q != '0 && d_q <= d_eff)
		else $error("power index outside 1..max_power");

	a_bias_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_exp_q == '0 |-> out_value_q == Q_ONE && out_col_q == '0
		&& out_last_q)
		else $error("bias result malformed");

endmodule
